// ===== sv/splc_pkg.sv =====
package splc_pkg;

    localparam int BUF_W   = 10;
    localparam int VOLT_W  = 12;
    localparam int PWR_W   = 14;
    localparam int FRAC_W  = 11;
    localparam int LVL_W   = 2;
    localparam int SQ_W    = 2 * VOLT_W;
    localparam int QUO_W   = 10;
    localparam int CFG_W   = 12;
    localparam int CFG_A_W = 3;
    localparam int CNT_W   = 4;

    // hysteresis levels
    localparam logic [LVL_W-1:0] LVL_LOW  = 2'd0;
    localparam logic [LVL_W-1:0] LVL_MID  = 2'd1;
    localparam logic [LVL_W-1:0] LVL_HIGH = 2'd2;

    // register indexes
    localparam logic [CFG_A_W-1:0] CFG_BUF_LOW  = 3'd0;
    localparam logic [CFG_A_W-1:0] CFG_BUF_MID  = 3'd1;
    localparam logic [CFG_A_W-1:0] CFG_BUF_HIGH = 3'd2;
    localparam logic [CFG_A_W-1:0] CFG_CAP_LOW  = 3'd3;
    localparam logic [CFG_A_W-1:0] CFG_CAP_MID  = 3'd4;
    localparam logic [CFG_A_W-1:0] CFG_CAP_HIGH = 3'd5;
    localparam logic [CFG_A_W-1:0] CFG_VMIN     = 3'd6;
    localparam logic [CFG_A_W-1:0] CFG_VMAX     = 3'd7;

    // register reset values
    localparam logic [BUF_W-1:0]  RST_BUF_LOW  = 10'd20;
    localparam logic [BUF_W-1:0]  RST_BUF_MID  = 10'd40;
    localparam logic [BUF_W-1:0]  RST_BUF_HIGH = 10'd50;
    localparam logic [VOLT_W-1:0] RST_CAP_LOW  = 12'd1300;
    localparam logic [VOLT_W-1:0] RST_CAP_MID  = 12'd1600;
    localparam logic [VOLT_W-1:0] RST_CAP_HIGH = 12'd1900;
    localparam logic [VOLT_W-1:0] RST_VMIN     = 12'd1000;
    localparam logic [VOLT_W-1:0] RST_VMAX     = 12'd2400;

    // 5 W in 0.1 W units
    localparam logic [PWR_W-1:0] LOSS_MARGIN = 14'd50;
    localparam logic [FRAC_W-1:0] FRAC_ONE = 11'd1024;

    // floor(x/5) == (x * 52429) >> 18 for any 16-bit x
    localparam int DIV5_IN_W = 16;
    localparam logic [15:0] RECIP5 = 16'd52429;
    localparam int RECIP5_SH = 18;

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);

    typedef enum logic [1:0] {
        MSEL_V,
        MSEL_LO,
        MSEL_HI
    } t_msel;

    typedef struct packed {
        logic  load;
        logic  mul_en;
        t_msel mul_sel;
        logic  upd_state;
        logic  prep;
        logic  div_step;
        logic  out_load;
    } t_splc_cmd;

endpackage

// ===== sv/splc_ctrl.sv =====
module splc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_out_stall,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output splc_pkg::t_splc_cmd  o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_V,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_PREP,
        ST_DIV,
        ST_FIN
    } t_state;

    t_state                        r_state;
    logic [splc_pkg::CNT_W-1:0]    r_cnt;
    logic                          r_out_valid;
    logic                          w_out_free;

    // output register can take a new result when empty or being drained
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd           = '0;
        o_cmd.mul_sel   = splc_pkg::MSEL_V;
        unique case (r_state)
            ST_IDLE:   o_cmd.load = i_in_valid;
            ST_MUL_V: begin
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_sel   = splc_pkg::MSEL_V;
                o_cmd.upd_state = 1'b1;
            end
            ST_MUL_LO: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = splc_pkg::MSEL_LO;
            end
            ST_MUL_HI: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = splc_pkg::MSEL_HI;
            end
            ST_PREP:   o_cmd.prep = 1'b1;
            ST_DIV:    o_cmd.div_step = 1'b1;
            ST_FIN:    o_cmd.out_load = w_out_free;
            default:   o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a result drained while the next one loads keeps valid high
            if (r_out_valid && !i_out_stall && !o_cmd.out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_MUL_V;
                    end
                end
                ST_MUL_V:  r_state <= ST_MUL_LO;
                ST_MUL_LO: r_state <= ST_MUL_HI;
                ST_MUL_HI: r_state <= ST_PREP;
                ST_PREP: begin
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == splc_pkg::DIV_LAST) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/splc_dp.sv =====
module splc_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [splc_pkg::CFG_A_W-1:0]       i_cfg_idx,
    input  logic [splc_pkg::CFG_W-1:0]         i_cfg_data,
    input  splc_pkg::t_splc_cmd                i_cmd,
    input  logic [splc_pkg::BUF_W-1:0]         i_buffer_joules,
    input  logic [splc_pkg::PWR_W-1:0]         i_power_limit,
    input  logic [splc_pkg::PWR_W-1:0]         i_requested_power,
    input  logic [splc_pkg::VOLT_W-1:0]        i_cap_voltage,
    output logic [splc_pkg::PWR_W-1:0]         o_chassis_power,
    output logic [splc_pkg::PWR_W-1:0]         o_charge_power,
    output logic [splc_pkg::FRAC_W-1:0]        o_energy_fraction,
    output logic [splc_pkg::LVL_W-1:0]         o_buffer_level,
    output logic [splc_pkg::LVL_W-1:0]         o_cap_level
);

    localparam int BW = splc_pkg::BUF_W;
    localparam int VW = splc_pkg::VOLT_W;
    localparam int PW = splc_pkg::PWR_W;
    localparam int SW = splc_pkg::SQ_W;
    localparam int QW = splc_pkg::QUO_W;
    localparam int XW = splc_pkg::DIV5_IN_W;

    // configuration
    logic [BW-1:0] r_buf_low, r_buf_mid, r_buf_high;
    logic [VW-1:0] r_cap_low, r_cap_mid, r_cap_high, r_vmin, r_vmax;

    // state
    logic [splc_pkg::LVL_W-1:0] r_buf_st, r_cap_st;

    // latched item
    logic [BW-1:0] r_e;
    logic [PW-1:0] r_lim, r_req;
    logic [VW-1:0] r_v;

    // energy fraction and charge paths
    logic [SW-1:0] r_v2, r_lo2, r_hi2;
    logic [SW-1:0] r_den, r_rem;
    logic [QW-1:0] r_quo;
    logic          r_frac_zero, r_frac_full;
    logic [2*XW-1:0] r_chg_prod;

    logic [VW-1:0] w_mul_a;
    logic [SW-1:0] w_mul_p;
    logic [SW-1:0] w_num, w_den;
    logic [SW:0]   w_trial;
    logic [XW-1:0] w_chg_x;

    function automatic logic [splc_pkg::LVL_W-1:0] next_buf(
        input logic [splc_pkg::LVL_W-1:0] s,
        input logic [BW-1:0] e,
        input logic [BW-1:0] lo,
        input logic [BW-1:0] mid,
        input logic [BW-1:0] hi
    );
        logic [splc_pkg::LVL_W-1:0] n;
        case (s)
            splc_pkg::LVL_HIGH:
                n = (e < mid) ? ((e < lo) ? splc_pkg::LVL_LOW : splc_pkg::LVL_MID)
                              : splc_pkg::LVL_HIGH;
            splc_pkg::LVL_MID:
                n = (e > hi) ? splc_pkg::LVL_HIGH
                             : ((e < lo) ? splc_pkg::LVL_LOW : splc_pkg::LVL_MID);
            default:
                n = (e > hi) ? splc_pkg::LVL_HIGH
                             : ((e > mid) ? splc_pkg::LVL_MID : splc_pkg::LVL_LOW);
        endcase
        return n;
    endfunction

    function automatic logic [splc_pkg::LVL_W-1:0] next_cap(
        input logic [splc_pkg::LVL_W-1:0] s,
        input logic [VW-1:0] v,
        input logic [VW-1:0] lo,
        input logic [VW-1:0] mid,
        input logic [VW-1:0] hi
    );
        logic [splc_pkg::LVL_W-1:0] n;
        case (s)
            splc_pkg::LVL_MID:
                n = (v > hi) ? splc_pkg::LVL_HIGH
                             : ((v < lo) ? splc_pkg::LVL_LOW : splc_pkg::LVL_MID);
            splc_pkg::LVL_HIGH:
                n = (v < mid) ? ((v < lo) ? splc_pkg::LVL_LOW : splc_pkg::LVL_MID)
                              : splc_pkg::LVL_HIGH;
            default:
                n = (v > mid) ? ((v > hi) ? splc_pkg::LVL_HIGH : splc_pkg::LVL_MID)
                              : splc_pkg::LVL_LOW;
        endcase
        return n;
    endfunction

    // one shared 12x12 squarer
    always_comb begin
        case (i_cmd.mul_sel)
            splc_pkg::MSEL_LO: w_mul_a = r_vmin;
            splc_pkg::MSEL_HI: w_mul_a = r_vmax;
            default:           w_mul_a = r_v;
        endcase
    end
    assign w_mul_p = w_mul_a * w_mul_a;

    assign w_num   = r_v2 - r_lo2;
    assign w_den   = r_hi2 - r_lo2;
    assign w_trial = {r_rem, 1'b0} - {1'b0, r_den};

    // lim*4 in the middle state, lim*3 otherwise; then /5
    assign w_chg_x = (r_buf_st == splc_pkg::LVL_MID) ? {r_lim, 2'b00}
                                                     : ({2'b00, r_lim} + {1'b0, r_lim, 1'b0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_low  <= splc_pkg::RST_BUF_LOW;
            r_buf_mid  <= splc_pkg::RST_BUF_MID;
            r_buf_high <= splc_pkg::RST_BUF_HIGH;
            r_cap_low  <= splc_pkg::RST_CAP_LOW;
            r_cap_mid  <= splc_pkg::RST_CAP_MID;
            r_cap_high <= splc_pkg::RST_CAP_HIGH;
            r_vmin     <= splc_pkg::RST_VMIN;
            r_vmax     <= splc_pkg::RST_VMAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                splc_pkg::CFG_BUF_LOW:  r_buf_low  <= i_cfg_data[BW-1:0];
                splc_pkg::CFG_BUF_MID:  r_buf_mid  <= i_cfg_data[BW-1:0];
                splc_pkg::CFG_BUF_HIGH: r_buf_high <= i_cfg_data[BW-1:0];
                splc_pkg::CFG_CAP_LOW:  r_cap_low  <= i_cfg_data[VW-1:0];
                splc_pkg::CFG_CAP_MID:  r_cap_mid  <= i_cfg_data[VW-1:0];
                splc_pkg::CFG_CAP_HIGH: r_cap_high <= i_cfg_data[VW-1:0];
                splc_pkg::CFG_VMIN:     r_vmin     <= i_cfg_data[VW-1:0];
                splc_pkg::CFG_VMAX:     r_vmax     <= i_cfg_data[VW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_st <= splc_pkg::LVL_HIGH;
            r_cap_st <= splc_pkg::LVL_LOW;
        end else if (i_cmd.upd_state) begin
            r_buf_st <= next_buf(r_buf_st, r_e, r_buf_low, r_buf_mid, r_buf_high);
            r_cap_st <= next_cap(r_cap_st, r_v, r_cap_low, r_cap_mid, r_cap_high);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_e   <= i_buffer_joules;
            r_lim <= i_power_limit;
            r_req <= i_requested_power;
            r_v   <= i_cap_voltage;
        end
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_sel)
                splc_pkg::MSEL_LO: r_lo2 <= w_mul_p;
                splc_pkg::MSEL_HI: r_hi2 <= w_mul_p;
                default:           r_v2  <= w_mul_p;
            endcase
        end
        if (i_cmd.prep) begin
            r_frac_zero <= (r_v2 <= r_lo2);
            // quotient reaches one whenever numerator >= denominator
            r_frac_full <= (r_hi2 <= r_lo2) || (w_num >= w_den);
            r_den       <= w_den;
            r_rem       <= w_num;
            r_quo       <= '0;
            r_chg_prod  <= w_chg_x * splc_pkg::RECIP5;
        end
        if (i_cmd.div_step) begin
            // restoring step; remainder stays below the denominator
            if (!w_trial[SW]) begin
                r_rem <= w_trial[SW-1:0];
                r_quo <= {r_quo[QW-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[SW-2:0], 1'b0};
                r_quo <= {r_quo[QW-2:0], 1'b0};
            end
        end
        if (i_cmd.out_load) begin
            if (r_cap_st == splc_pkg::LVL_MID || r_cap_st == splc_pkg::LVL_HIGH) begin
                o_chassis_power <= r_req;
            end else if (r_lim > splc_pkg::LOSS_MARGIN) begin
                o_chassis_power <= r_lim - splc_pkg::LOSS_MARGIN;
            end else begin
                o_chassis_power <= '0;
            end
            if (r_buf_st == splc_pkg::LVL_HIGH) begin
                o_charge_power <= r_lim;
            end else begin
                o_charge_power <= r_chg_prod[splc_pkg::RECIP5_SH +: PW];
            end
            if (r_frac_zero) begin
                o_energy_fraction <= '0;
            end else if (r_frac_full) begin
                o_energy_fraction <= splc_pkg::FRAC_ONE;
            end else begin
                o_energy_fraction <= {1'b0, r_quo};
            end
            o_buffer_level <= r_buf_st;
            o_cap_level    <= r_cap_st;
        end
    end

endmodule

// ===== sv/supercap_power_limit_controller.sv =====
// Channel  Handshake                 Payload
// input    i_in_valid / o_in_stall   buffer_joules, power_limit, requested_power, cap_voltage
// output   o_out_valid / i_out_stall chassis_power, charge_power, energy_fraction, levels
// config   i_cfg_we                  i_cfg_idx, i_cfg_data
//
// One item at a time: a new item is taken only after the current one has made three passes
// through the shared squarer, a prep step and a 10-step restoring divider for the energy
// fraction, and its result has been written to the output register.
// Synchronous active-low reset restores the thresholds, buffer state high, cap state low.
// A stalled result holds in the output register; a new item is still taken meanwhile,
// and only its final write waits for the output register to drain.
module supercap_power_limit_controller (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [splc_pkg::CFG_A_W-1:0]       i_cfg_idx,
    input  logic [splc_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [splc_pkg::BUF_W-1:0]         i_buffer_joules,
    input  logic [splc_pkg::PWR_W-1:0]         i_power_limit,
    input  logic [splc_pkg::PWR_W-1:0]         i_requested_power,
    input  logic [splc_pkg::VOLT_W-1:0]        i_cap_voltage,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [splc_pkg::PWR_W-1:0]         o_chassis_power,
    output logic [splc_pkg::PWR_W-1:0]         o_charge_power,
    output logic [splc_pkg::FRAC_W-1:0]        o_energy_fraction,
    output logic [splc_pkg::LVL_W-1:0]         o_buffer_level,
    output logic [splc_pkg::LVL_W-1:0]         o_cap_level
);

    splc_pkg::t_splc_cmd w_cmd;

    splc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    splc_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_cmd             (w_cmd),
        .i_buffer_joules   (i_buffer_joules),
        .i_power_limit     (i_power_limit),
        .i_requested_power (i_requested_power),
        .i_cap_voltage     (i_cap_voltage),
        .o_chassis_power   (o_chassis_power),
        .o_charge_power    (o_charge_power),
        .o_energy_fraction (o_energy_fraction),
        .o_buffer_level    (o_buffer_level),
        .o_cap_level       (o_cap_level)
    );

endmodule

// ===== sv/splc_chk.sv =====
module splc_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic [splc_pkg::PWR_W-1:0]         o_chassis_power,
    input logic [splc_pkg::FRAC_W-1:0]        o_energy_fraction,
    input logic [splc_pkg::LVL_W-1:0]         o_buffer_level,
    input logic [splc_pkg::LVL_W-1:0]         o_cap_level
);

    // no result survives a reset
    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // an input transfer makes the block busy for the following cycle
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after transfer");

    // fraction never exceeds one
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_energy_fraction <= splc_pkg::FRAC_ONE)
        else $error("energy fraction above one");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_chassis_power)
            && $stable(o_buffer_level) && $stable(o_cap_level))
        else $error("stalled result changed");

endmodule

bind supercap_power_limit_controller splc_chk u_splc_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_chassis_power   (o_chassis_power),
    .o_energy_fraction (o_energy_fraction),
    .o_buffer_level    (o_buffer_level),
    .o_cap_level       (o_cap_level)
);

// ===== tb/supercap_power_limit_controller_test.sv =====
module supercap_power_limit_controller_test;
    import splc_pkg::*;

    typedef struct packed {
        logic [PWR_W-1:0]  chassis;
        logic [PWR_W-1:0]  charge;
        logic [FRAC_W-1:0] fraction;
        logic [LVL_W-1:0]  buffer_lvl;
        logic [LVL_W-1:0]  cap_lvl;
    } t_grant;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_A_W-1:0]   i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [BUF_W-1:0]     i_buffer_joules;
    logic [PWR_W-1:0]     i_power_limit;
    logic [PWR_W-1:0]     i_requested_power;
    logic [VOLT_W-1:0]    i_cap_voltage;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [PWR_W-1:0]     o_chassis_power;
    logic [PWR_W-1:0]     o_charge_power;
    logic [FRAC_W-1:0]    o_energy_fraction;
    logic [LVL_W-1:0]     o_buffer_level;
    logic [LVL_W-1:0]     o_cap_level;

    t_grant pending_grants[$];
    int     mismatches = 0;
    bit     idling = 1'b1;
    int     out_hold = 0;

    // predictor copy of registers and state
    logic [BUF_W-1:0]  buf_lo, buf_mid, buf_hi;
    logic [VOLT_W-1:0] cap_lo, cap_mid, cap_hi, v_empty, v_full;
    logic [LVL_W-1:0]  buffer_lvl, cap_lvl;

    logic [CFG_W-1:0]  reg_plan [0:7];

    always #4 i_clk = ~i_clk;

    supercap_power_limit_controller uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_buffer_joules   (i_buffer_joules),
        .i_power_limit     (i_power_limit),
        .i_requested_power (i_requested_power),
        .i_cap_voltage     (i_cap_voltage),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_chassis_power   (o_chassis_power),
        .o_charge_power    (o_charge_power),
        .o_energy_fraction (o_energy_fraction),
        .o_buffer_level    (o_buffer_level),
        .o_cap_level       (o_cap_level)
    );

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatches < 100)
            $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    function automatic logic [FRAC_W-1:0] usable_energy(input logic [VOLT_W-1:0] v);
        longint unsigned v2, lo2, hi2, q;
        v2 = 64'(v);
        v2 = v2 * v2;
        lo2 = 64'(v_empty);
        lo2 = lo2 * lo2;
        hi2 = 64'(v_full);
        hi2 = hi2 * hi2;
        if (v2 <= lo2)
            return '0;
        if (hi2 <= lo2)
            return FRAC_ONE;
        q = ((v2 - lo2) * FRAC_ONE) / (hi2 - lo2);
        return (q > FRAC_ONE) ? FRAC_ONE : FRAC_W'(q);
    endfunction

    function automatic logic [LVL_W-1:0] next_buffer_level(input logic [LVL_W-1:0] s,
                                                           input logic [BUF_W-1:0] e);
        case (s)
            LVL_HIGH: return (e < buf_mid) ? ((e < buf_lo) ? LVL_LOW : LVL_MID) : LVL_HIGH;
            LVL_MID:  return (e > buf_hi) ? LVL_HIGH : ((e < buf_lo) ? LVL_LOW : LVL_MID);
            default:  return (e > buf_hi) ? LVL_HIGH : ((e > buf_mid) ? LVL_MID : LVL_LOW);
        endcase
    endfunction

    function automatic logic [LVL_W-1:0] next_cap_level(input logic [LVL_W-1:0] s,
                                                        input logic [VOLT_W-1:0] v);
        case (s)
            LVL_MID:  return (v > cap_hi) ? LVL_HIGH : ((v < cap_lo) ? LVL_LOW : LVL_MID);
            LVL_HIGH: return (v < cap_mid) ? ((v < cap_lo) ? LVL_LOW : LVL_MID) : LVL_HIGH;
            default:  return (v > cap_mid) ? ((v > cap_hi) ? LVL_HIGH : LVL_MID) : LVL_LOW;
        endcase
    endfunction

    task automatic predict_grant(input logic [BUF_W-1:0] e, input logic [PWR_W-1:0] lim,
                                 input logic [PWR_W-1:0] req, input logic [VOLT_W-1:0] v);
        t_grant g;
        g.fraction = usable_energy(v);
        buffer_lvl = next_buffer_level(buffer_lvl, e);
        if (buffer_lvl == LVL_HIGH)
            g.charge = lim;
        else if (buffer_lvl == LVL_MID)
            g.charge = PWR_W'((32'(lim) * 8) / 10);
        else
            g.charge = PWR_W'((32'(lim) * 6) / 10);
        cap_lvl = next_cap_level(cap_lvl, v);
        if (cap_lvl == LVL_MID || cap_lvl == LVL_HIGH)
            g.chassis = req;
        else
            g.chassis = (lim > LOSS_MARGIN) ? lim - LOSS_MARGIN : '0;
        g.buffer_lvl = buffer_lvl;
        g.cap_lvl = cap_lvl;
        pending_grants.push_back(g);
    endtask

    task automatic store_register(input logic [CFG_A_W-1:0] idx, input logic [CFG_W-1:0] d);
        case (idx)
            CFG_BUF_LOW:  buf_lo = d[BUF_W-1:0];
            CFG_BUF_MID:  buf_mid = d[BUF_W-1:0];
            CFG_BUF_HIGH: buf_hi = d[BUF_W-1:0];
            CFG_CAP_LOW:  cap_lo = d;
            CFG_CAP_MID:  cap_mid = d;
            CFG_CAP_HIGH: cap_hi = d;
            CFG_VMIN:     v_empty = d;
            CFG_VMAX:     v_full = d;
            default: ;
        endcase
    endtask

    // block must be idle here
    task automatic apply_registers();
        for (int i = 0; i < 8; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= CFG_A_W'(i);
            i_cfg_data <= reg_plan[i];
            @(posedge i_clk);
            store_register(CFG_A_W'(i), reg_plan[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_tick(input logic [BUF_W-1:0] e, input logic [PWR_W-1:0] lim,
                             input logic [PWR_W-1:0] req, input logic [VOLT_W-1:0] v);
        int gap;
        gap = 0;
        if (idling && $urandom_range(0, 3) == 0)
            gap = int'($urandom_range(1, 4));
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_buffer_joules <= e;
        i_power_limit <= lim;
        i_requested_power <= req;
        i_cap_voltage <= v;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predict_grant(e, lim, req, v);
    endtask

    // stop sending and let every pending result come out
    task automatic drain_results();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (pending_grants.size() != 0 && waited < 4000) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_grants.size() != 0) begin
            report_mismatch("results never delivered", 0, unsigned'(pending_grants.size()));
            pending_grants.delete();
        end
        repeat (20) @(posedge i_clk);
    endtask

    function automatic int unsigned near(input int unsigned c, input int unsigned top);
        int x;
        x = int'(c) + int'($urandom_range(0, 6)) - 3;
        if (x < 0)
            x = 0;
        if (x > int'(top))
            x = int'(top);
        return unsigned'(x);
    endfunction

    task automatic send_random_tick();
        logic [BUF_W-1:0]  e;
        logic [PWR_W-1:0]  lim, req;
        logic [VOLT_W-1:0] v;
        case ($urandom_range(0, 5))
            3:       e = BUF_W'(near(32'(buf_lo), 1023));
            4:       e = BUF_W'(near(32'(buf_mid), 1023));
            5:       e = BUF_W'(near(32'(buf_hi), 1023));
            default: e = BUF_W'($urandom);
        endcase
        case ($urandom_range(0, 7))
            3:       v = VOLT_W'(near(32'(cap_lo), 4095));
            4:       v = VOLT_W'(near(32'(cap_mid), 4095));
            5:       v = VOLT_W'(near(32'(cap_hi), 4095));
            6:       v = VOLT_W'(near(32'(v_empty), 4095));
            7:       v = VOLT_W'(near(32'(v_full), 4095));
            default: v = VOLT_W'($urandom);
        endcase
        if ($urandom_range(0, 3) == 0)
            lim = PWR_W'(near(32'(LOSS_MARGIN), 16383));
        else
            lim = PWR_W'($urandom);
        req = PWR_W'($urandom);
        send_tick(e, lim, req, v);
    endtask

    task automatic plan_ordered();
        reg_plan[CFG_BUF_LOW] = CFG_W'($urandom_range(0, 300));
        reg_plan[CFG_BUF_MID] = CFG_W'(32'(reg_plan[CFG_BUF_LOW]) + $urandom_range(0, 300));
        reg_plan[CFG_BUF_HIGH] = CFG_W'(32'(reg_plan[CFG_BUF_MID]) + $urandom_range(0, 400));
        // junk above bit 9 of the buffer levels must be dropped
        reg_plan[CFG_BUF_LOW][CFG_W-1:BUF_W] = (CFG_W-BUF_W)'($urandom);
        reg_plan[CFG_BUF_MID][CFG_W-1:BUF_W] = (CFG_W-BUF_W)'($urandom);
        reg_plan[CFG_BUF_HIGH][CFG_W-1:BUF_W] = (CFG_W-BUF_W)'($urandom);
        reg_plan[CFG_CAP_LOW] = CFG_W'($urandom_range(0, 1500));
        reg_plan[CFG_CAP_MID] = CFG_W'(32'(reg_plan[CFG_CAP_LOW]) + $urandom_range(0, 1200));
        reg_plan[CFG_CAP_HIGH] = CFG_W'(32'(reg_plan[CFG_CAP_MID]) + $urandom_range(0, 1300));
        reg_plan[CFG_VMIN] = CFG_W'($urandom_range(0, 3000));
        reg_plan[CFG_VMAX] = CFG_W'($urandom_range(32'(reg_plan[CFG_VMIN]) + 1, 4095));
    endtask

    task automatic plan_scrambled();
        for (int i = 0; i < 8; i++)
            reg_plan[i] = CFG_W'($urandom);
    endtask

    always @(posedge i_clk) begin : grant_check
        t_grant want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_grants.size() == 0) begin
                report_mismatch("result with nothing pending", 32'(o_chassis_power), 0);
            end else begin
                want = pending_grants.pop_front();
                if (o_chassis_power !== want.chassis)
                    report_mismatch("chassis_power", 32'(o_chassis_power),
                                    32'(want.chassis));
                if (o_charge_power !== want.charge)
                    report_mismatch("charge_power", 32'(o_charge_power), 32'(want.charge));
                if (o_energy_fraction !== want.fraction)
                    report_mismatch("energy_fraction", 32'(o_energy_fraction),
                                    32'(want.fraction));
                if (o_buffer_level !== want.buffer_lvl)
                    report_mismatch("buffer_level", 32'(o_buffer_level),
                                    32'(want.buffer_lvl));
                if (o_cap_level !== want.cap_lvl)
                    report_mismatch("cap_level", 32'(o_cap_level), 32'(want.cap_lvl));
            end
        end
        if (out_hold > 0)
            out_hold--;
        else if (idling && $urandom_range(0, 4) == 0)
            out_hold = int'($urandom_range(1, 4));
        i_out_stall <= (out_hold > 0);
    end

    // reset thresholds; walks both machines over each strict boundary between adjacent levels
    task automatic test_reset_defaults();
        send_tick(10'd1023, 14'd16383, 14'd16383, 12'd4095);
        send_tick(10'd40, 14'd1000, 14'd0, 12'd1600);
        send_tick(10'd39, 14'd1001, 14'd1, 12'd1599);
        send_tick(10'd50, 14'd7, 14'd2, 12'd1900);
        send_tick(10'd20, 14'd9, 14'd3, 12'd1300);
        send_tick(10'd19, 14'd51, 14'd4, 12'd1299);
        send_tick(10'd40, 14'd50, 14'd5, 12'd1600);
        send_tick(10'd41, 14'd49, 14'd6, 12'd1601);
        send_tick(10'd51, 14'd0, 14'd7, 12'd1901);
        send_tick(10'd0, 14'd16383, 14'd0, 12'd1000);
        send_tick(10'd1023, 14'd0, 14'd16383, 12'd0);
        send_tick(10'd50, 14'd12345, 14'd9999, 12'd1001);
        send_tick(10'd0, 14'd16383, 14'd8191, 12'd2400);
        send_tick(10'd1023, 14'd8192, 14'd1, 12'd2401);
    endtask

    task automatic test_register_extremes();
        drain_results();
        for (int i = 0; i < 8; i++)
            reg_plan[i] = '0;
        reg_plan[CFG_VMAX] = 12'd4095;
        apply_registers();
        send_tick(10'd0, 14'd0, 14'd0, 12'd0);
        send_tick(10'd1023, 14'd16383, 14'd100, 12'd4095);
        send_tick(10'd1, 14'd3, 14'd200, 12'd1);

        // empty voltage at or above the full voltage
        drain_results();
        for (int i = 0; i < 8; i++)
            reg_plan[i] = 12'd4095;
        reg_plan[CFG_VMAX] = 12'd1;
        apply_registers();
        send_tick(10'd1023, 14'd60, 14'd300, 12'd4095);
        send_tick(10'd0, 14'd16383, 14'd400, 12'd0);

        // thresholds out of order
        drain_results();
        reg_plan[CFG_BUF_LOW] = 12'd900;
        reg_plan[CFG_BUF_MID] = 12'd100;
        reg_plan[CFG_BUF_HIGH] = 12'd50;
        reg_plan[CFG_CAP_LOW] = 12'd3000;
        reg_plan[CFG_CAP_MID] = 12'd2000;
        reg_plan[CFG_CAP_HIGH] = 12'd1000;
        reg_plan[CFG_VMIN] = 12'd3000;
        reg_plan[CFG_VMAX] = 12'd2000;
        apply_registers();
        send_tick(10'd500, 14'd1234, 14'd500, 12'd3001);
        send_tick(10'd75, 14'd4321, 14'd600, 12'd3000);
        send_tick(10'd950, 14'd999, 14'd700, 12'd1500);
        send_tick(10'd20, 14'd16000, 14'd800, 12'd2500);
    endtask

    task automatic test_random_ticks();
        for (int phase = 0; phase < 6; phase++) begin
            drain_results();
            if (phase == 2)
                plan_scrambled();
            else
                plan_ordered();
            apply_registers();
            for (int n = 0; n < 108; n++) begin
                // final phase runs at full rate on both sides
                idling = (phase != 5) && (n % 80 < 60);
                send_random_tick();
            end
        end
    endtask

    task automatic reset_predictor();
        buf_lo = RST_BUF_LOW;
        buf_mid = RST_BUF_MID;
        buf_hi = RST_BUF_HIGH;
        cap_lo = RST_CAP_LOW;
        cap_mid = RST_CAP_MID;
        cap_hi = RST_CAP_HIGH;
        v_empty = RST_VMIN;
        v_full = RST_VMAX;
        buffer_lvl = LVL_HIGH;
        cap_lvl = LVL_LOW;
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_BUF_LOW;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_buffer_joules <= '0;
        i_power_limit <= '0;
        i_requested_power <= '0;
        i_cap_voltage <= '0;
        reset_predictor();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_register_extremes();
        test_random_ticks();
        drain_results();

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
